/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// implication or plain property checked every clock outside reset
`define LFU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lfu assertion failed");
// condition that must never be seen outside reset
`define LFU_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lfu forbidden condition seen");
`else
`define LFU_ASSERT(lbl, clk, rst_n, prop)
`define LFU_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* rtl/lfu_pkg.sv */
`default_nettype none
package lfu_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 31;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned STAMP_W = 64;
  localparam int unsigned CFG_W   = 7;

  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  // request op codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [CNT_W-1:0]   count;
    logic [STAMP_W-1:0] stamp;
  } ent_t;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic scan_start;
    logic commit;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/lfu_ctrl.sv */
`default_nettype none
`include "assert_macros.svh"
module lfu_ctrl import lfu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_COMMIT = 5'b01000,
    ST_RESP   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // request taken only between requests
  assign in_stall = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  `LFU_ASSERT(a_scan_in_scan, clk, rst_n, sts.scan_done |-> state_r == ST_SCAN)
  `LFU_ASSERT(a_commit_resp, clk, rst_n, state_r == ST_COMMIT |=> state_r == ST_RESP)
  `LFU_ASSERT(a_accept_scan, clk, rst_n, (in_valid && !in_stall) |=> state_r == ST_SCAN)

endmodule
`default_nettype wire

/* rtl/lfu_datapath.sv */
`default_nettype none
`include "assert_macros.svh"
module lfu_datapath import lfu_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire in_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_t                  out_data,
  input  wire cmd_t             cmd,
  output sts_t                  sts
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned UW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (UW > CFG_W) ? UW : CFG_W;
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  ent_t mem [CAPACITY];

  logic [CFG_W-1:0]   cap_r;
  in_t                req_r;
  logic [AW-1:0]      clr_cnt_r;
  logic               issuing_r;
  logic [AW-1:0]      iss_r;
  logic               eval_vld_r;
  logic [AW-1:0]      eval_idx_r;
  ent_t               rdata_r;
  logic [STAMP_W-1:0] clock_r;

  logic               hit_r;
  logic [AW-1:0]      hit_idx_r;
  ent_t               hit_ent_r;
  logic [UW-1:0]      used_r;
  logic               free_r;
  logic [AW-1:0]      free_idx_r;
  logic               vic_r;
  logic [AW-1:0]      vic_idx_r;
  logic [KEY_W-1:0]   vic_key_r;
  logic [CNT_W-1:0]   vic_cnt_r;
  logic [STAMP_W-1:0] vic_stamp_r;

  out_t               res_r;
  logic               out_valid_r;
  out_t               out_data_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n)      cap_r <= CAP_RESET;
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.scan_start) req_r <= in_data;
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n)          clr_cnt_r <= '0;
    else if (cmd.clr_en) clr_cnt_r <= clr_cnt_r + AW'(1);
  end
  assign sts.clr_last = (clr_cnt_r == LAST);

  // scan read issue, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r  <= 1'b0;
      eval_vld_r <= 1'b0;
      iss_r      <= '0;
    end else begin
      eval_vld_r <= issuing_r;
      if (cmd.scan_start) begin
        issuing_r <= 1'b1;
        iss_r     <= '0;
      end else if (issuing_r) begin
        iss_r <= iss_r + AW'(1);
        if (iss_r == LAST) issuing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r <= iss_r;
  end
  assign sts.scan_done = eval_vld_r && (eval_idx_r == LAST);

  // commit decision
  logic [CW-1:0]      cap_ext, cap_eff;
  logic               put_ok, do_touch, do_evict, do_ins, mem_we;
  logic [AW-1:0]      slot, waddr;
  ent_t               went, wdata;
  logic [STAMP_W-1:0] stamp_nxt;
  logic [CNT_W-1:0]   cnt_inc;

  always_comb begin
    cap_ext   = CW'(cap_r);
    cap_eff   = (cap_ext > CW'(CAPACITY)) ? CW'(CAPACITY) : cap_ext;
    put_ok    = (req_r.op == OP_PUT) && (cap_eff != '0);
    do_touch  = hit_r && ((req_r.op == OP_GET) || put_ok);
    do_evict  = put_ok && !hit_r && (CW'(used_r) >= cap_eff) && vic_r;
    do_ins    = put_ok && !hit_r && (do_evict || free_r);
    slot      = hit_r ? hit_idx_r : (do_evict ? vic_idx_r : free_idx_r);
    stamp_nxt = clock_r + STAMP_W'(1);
    cnt_inc   = (hit_ent_r.count == CNT_MAX) ? CNT_MAX : hit_ent_r.count + CNT_W'(1);
    went.valid = 1'b1;
    went.key   = req_r.key;
    went.value = (req_r.op == OP_PUT) ? req_r.value : hit_ent_r.value;
    went.count = hit_r ? cnt_inc : CNT_W'(1);
    went.stamp = stamp_nxt;
    mem_we = cmd.clr_en || (cmd.commit && (do_touch || do_ins));
    waddr  = cmd.clr_en ? clr_cnt_r : slot;
    wdata  = cmd.clr_en ? ent_t'('0) : went;
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we)    mem[waddr] <= wdata;
    if (issuing_r) rdata_r    <= mem[iss_r];
  end

  // use clock
  always_ff @(posedge clk) begin
    if (!rst_n) clock_r <= '0;
    else if (cmd.commit && (do_touch || do_ins)) clock_r <= stamp_nxt;
  end

  // per-entry evaluation: key match, occupancy, free slot, victim
  logic vic_better;
  always_comb begin
    vic_better = !vic_r || (rdata_r.count < vic_cnt_r) ||
                 ((rdata_r.count == vic_cnt_r) && (rdata_r.stamp < vic_stamp_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      hit_r  <= 1'b0;
      used_r <= '0;
      free_r <= 1'b0;
      vic_r  <= 1'b0;
    end else if (eval_vld_r) begin
      if (rdata_r.valid) begin
        used_r <= used_r + UW'(1);
        if (rdata_r.key == req_r.key) begin
          hit_r     <= 1'b1;
          hit_idx_r <= eval_idx_r;
          hit_ent_r <= rdata_r;
        end
        if (vic_better) begin
          vic_r       <= 1'b1;
          vic_idx_r   <= eval_idx_r;
          vic_key_r   <= rdata_r.key;
          vic_cnt_r   <= rdata_r.count;
          vic_stamp_r <= rdata_r.stamp;
        end
      end else if (!free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= eval_idx_r;
      end
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r.hit         <= hit_r;
      res_r.read_value  <= (req_r.op == OP_GET && hit_r) ? hit_ent_r.value : '0;
      res_r.evicted     <= do_evict;
      res_r.evicted_key <= do_evict ? vic_key_r : '0;
    end
  end

  // output register
  assign sts.out_free = !out_valid_r || !out_stall;
  always_ff @(posedge clk) begin
    if (!rst_n)            out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (!out_stall)   out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= res_r;
  end
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LFU_NEVER(a_no_write_in_scan, clk, rst_n, mem_we && (issuing_r || eval_vld_r))
  `LFU_ASSERT(a_one_victim_evict, clk, rst_n, (cmd.commit && do_evict) |-> !hit_r)
  `LFU_ASSERT(a_used_bound, clk, rst_n, cmd.commit |-> used_r <= UW'(CAPACITY))

endmodule
`default_nettype wire

/* rtl/lfu_cache_table.sv */
// a request is scanned over every entry, committed, then loaded into the output
//   register; the next request is taken only after that load, the scan running
//   through the single read port of the entry memory, one entry a cycle
// reset: synchronous active low; a clearing pass over every entry follows,
//   during which requests stall (configuration writes are taken)
`default_nettype none
module lfu_cache_table import lfu_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_t                  out_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // entry store and scan datapath
  lfu_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

/* tb/sv/lfu_cache_table_tb.sv */
`default_nettype none
module lfu_cache_table_tb;
  import lfu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 64;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = SLOTS + 16;

  // behavioral copy of the cache, one request at a time
  class lfu_scoreboard;
    bit [CFG_W-1:0] capacity;
    bit ent_valid[SLOTS];
    bit [KEY_W-1:0] ent_key[SLOTS];
    bit [VAL_W-1:0] ent_value[SLOTS];
    bit [CNT_W-1:0] ent_count[SLOTS];
    bit [STAMP_W-1:0] ent_stamp[SLOTS];
    bit [STAMP_W-1:0] use_clock;
    out_t pending[$];
    int unsigned errors;

    function void clear();
      capacity = CAP_RESET;
      use_clock = '0;
      for (int i = 0; i < SLOTS; i++) begin
        ent_valid[i] = 1'b0;
        ent_count[i] = '0;
        ent_stamp[i] = '0;
      end
      pending.delete();
      errors = 0;
    endfunction

    function void set_capacity(bit [CFG_W-1:0] c);
      capacity = c;
    endfunction

    function void note_request(in_t req);
      out_t res;
      int slot;
      int victim;
      int target;
      int unsigned used;
      int unsigned cap;
      res = '0;
      slot = -1;
      victim = -1;
      target = -1;
      used = 0;
      cap = (capacity > SLOTS) ? SLOTS : capacity;
      for (int i = 0; i < SLOTS; i++)
        if (slot < 0 && ent_valid[i] && ent_key[i] == req.key) slot = i;
      res.hit = (slot >= 0);
      if (req.op == OP_GET) begin
        if (slot >= 0) begin
          if (ent_count[slot] != CNT_MAX) ent_count[slot]++;
          use_clock++;
          ent_stamp[slot] = use_clock;
          res.read_value = ent_value[slot];
        end
      end else if (cap != 0) begin
        if (slot >= 0) begin
          ent_value[slot] = req.value;
          if (ent_count[slot] != CNT_MAX) ent_count[slot]++;
          use_clock++;
          ent_stamp[slot] = use_clock;
        end else begin
          for (int i = 0; i < SLOTS; i++) if (ent_valid[i]) used++;
          // least count, then oldest stamp, then lowest slot
          if (used >= cap) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!ent_valid[i]) continue;
              if (victim < 0 || ent_count[i] < ent_count[victim] ||
                  (ent_count[i] == ent_count[victim] &&
                   ent_stamp[i] < ent_stamp[victim]))
                victim = i;
            end
            if (victim >= 0) begin
              res.evicted = 1'b1;
              res.evicted_key = ent_key[victim];
              ent_valid[victim] = 1'b0;
              target = victim;
            end
          end
          if (target < 0)
            for (int i = 0; i < SLOTS; i++)
              if (target < 0 && !ent_valid[i]) target = i;
          if (target >= 0) begin
            ent_valid[target] = 1'b1;
            ent_key[target] = req.key;
            ent_value[target] = req.value;
            ent_count[target] = 1;
            use_clock++;
            ent_stamp[target] = use_clock;
          end
        end
      end
      pending.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.hit !== exp.hit) begin
        $error("hit: expected %0d actual %0d", exp.hit, got.hit);
        errors++;
      end
      if (got.read_value !== exp.read_value) begin
        $error("read_value: expected %0h actual %0h", exp.read_value, got.read_value);
        errors++;
      end
      if (got.evicted !== exp.evicted) begin
        $error("evicted: expected %0d actual %0d", exp.evicted, got.evicted);
        errors++;
      end
      if (got.evicted_key !== exp.evicted_key) begin
        $error("evicted_key: expected %0h actual %0h", exp.evicted_key, got.evicted_key);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  lfu_scoreboard lfu_model;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned idle_cycles = 0;
  bit [KEY_W-1:0] key_pool[16];

  always #10 clk = ~clk;

  lfu_cache_table #(.CAPACITY(SLOTS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // result sampling, receiver stall and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) lfu_model.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_idle_pct);

  // one request through the handshake, with random sender gaps
  task automatic send_request(in_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lfu_model.note_request(req);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (lfu_model.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(bit [CFG_W-1:0] c);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we <= 1'b0;
    lfu_model.set_capacity(c);
  endtask

  function automatic in_t make_request(bit op, bit [KEY_W-1:0] k, bit [VAL_W-1:0] v);
    in_t r;
    r.op = op;
    r.key = k;
    r.value = v;
    return r;
  endfunction

  // mostly keys from a small pool so hits and evictions are common
  task automatic random_phase(int unsigned n);
    bit [KEY_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) k = key_pool[$urandom_range(15)];
      else k = $urandom;
      send_request(make_request(1'($urandom_range(1)), k, VAL_W'($urandom)));
    end
  endtask

  initial begin
    bit [CFG_W-1:0] caps[8];
    lfu_model = new();
    lfu_model.clear();
    caps = '{7'd3, 7'd0, 7'd127, 7'd1, 7'd64, 7'd8, 7'd65, 7'd12};
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: capacity two, ties, counts, overwrite, extremes
    write_capacity(7'd2);
    send_request(make_request(OP_GET, 32'h0, 31'h7fffffff));
    send_request(make_request(OP_PUT, 32'h0, 31'h7fffffff));
    send_request(make_request(OP_PUT, 32'hffffffff, 31'h0));
    send_request(make_request(OP_GET, 32'h0, 31'h0));
    send_request(make_request(OP_PUT, 32'h12345678, 31'h1));
    send_request(make_request(OP_PUT, 32'hffffffff, 31'h55555555));
    send_request(make_request(OP_GET, 32'hffffffff, 31'h2aaaaaaa));
    send_request(make_request(OP_PUT, 32'haaaaaaaa, 31'h2aaaaaaa));
    send_request(make_request(OP_GET, 32'h12345678, 31'h0));
    wait_drained();
    // disabled puts still report hit
    write_capacity(7'd0);
    send_request(make_request(OP_PUT, 32'hffffffff, 31'h3));
    send_request(make_request(OP_PUT, 32'h5555aaaa, 31'h4));
    send_request(make_request(OP_GET, 32'hffffffff, 31'h0));
    wait_drained();
    // lowered below occupancy: one eviction per new put
    write_capacity(7'd1);
    send_request(make_request(OP_PUT, 32'h00000001, 31'h9));
    send_request(make_request(OP_PUT, 32'h00000002, 31'h8));
    send_request(make_request(OP_GET, 32'h00000002, 31'h0));
    wait_drained();
    // fill past the table size with capacity above it
    write_capacity(7'd127);
    for (int i = 0; i < 70; i++)
      send_request(make_request(OP_PUT, KEY_W'(32'h1000 + i), VAL_W'(i)));
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 0) begin
        send_idle_pct = 8;
        recv_idle_pct = 70;
      end else if (ph == 1) begin
        send_idle_pct = 70;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int c = 0; c < 3; c++) begin
        write_capacity(caps[(ph * 3 + c) % 8]);
        random_phase(140);
        wait_drained();
      end
    end

    wait_drained();
    if (lfu_model.errors == 0 && lfu_model.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* lfu_cache_table.f */
+incdir+rtl
rtl/lfu_pkg.sv
rtl/lfu_ctrl.sv
rtl/lfu_datapath.sv
rtl/lfu_cache_table.sv
tb/sv/lfu_cache_table_tb.sv
